@@ rtl/mdrd_pkg.sv @@
`default_nettype none
package mdrd_pkg;

    localparam int unsigned NREGS  = 10;
    localparam int unsigned RIDX_W = $clog2(NREGS);

    localparam logic [7:0] ADDR_DEFAULT = 8'h26;
    localparam logic [7:0] SAVE_ADDR    = 8'd127;
    localparam logic [7:0] NREGS_ADDR   = 8'(NREGS);

    // register map
    localparam logic [RIDX_W-1:0] R_ADDR   = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] R_STATUS = RIDX_W'(1);
    localparam logic [RIDX_W-1:0] R_DIR    = RIDX_W'(2);
    localparam logic [RIDX_W-1:0] R_SPEED1 = RIDX_W'(4);
    localparam logic [RIDX_W-1:0] R_SPEED2 = RIDX_W'(5);
    localparam logic [RIDX_W-1:0] R_INOPT0 = RIDX_W'(6);
    localparam logic [RIDX_W-1:0] R_INOPT1 = RIDX_W'(7);
    localparam logic [RIDX_W-1:0] R_IMASK0 = RIDX_W'(8);
    localparam logic [RIDX_W-1:0] R_IMASK1 = RIDX_W'(9);

    // status bits 4/5 are the latched interrupts
    localparam logic [7:0] ST_INTS = 8'h30;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_PIN   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [3:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] direction_pins;
        logic [1:0] pwm_enable;
        logic [7:0] duty_m1;
        logic [7:0] duty_m2;
        logic [3:0] pullups;
        logic [1:0] int_drive;
        logic       save_request;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/mdrd_in_stage.sv @@
`default_nettype none
module mdrd_in_stage (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_ready,
    input  mdrd_pkg::req_t in_req,
    input  wire           advance,
    output logic          req_valid,
    output mdrd_pkg::req_t req
);
    import mdrd_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign in_ready  = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

endmodule
`default_nettype wire

@@ rtl/mdrd_regfile.sv @@
`default_nettype none
module mdrd_regfile (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              step,
    input  mdrd_pkg::req_t   req,
    output mdrd_pkg::result_t result
);
    import mdrd_pkg::*;

    logic [7:0] rf_reg [NREGS];
    logic [7:0] rf_next [NREGS];
    logic [1:0] pwm_on_reg, pwm_on_next;
    logic [7:0] duty_reg [2];
    logic [7:0] duty_next [2];
    logic [3:0] pullup_reg, pullup_next;
    logic [1:0] drive_reg, drive_next;

    logic [RIDX_W-1:0] idx;
    logic              in_file;
    logic [7:0]        rd;
    logic              save;
    logic [3:0]        val;
    logic [3:0]        limit;
    logic              int0;
    logic              int1;

    assign idx     = req.reg_addr[RIDX_W-1:0];
    assign in_file = req.reg_addr < NREGS_ADDR;

    // per-input invert and limit options, two inputs per option register
    assign val   = req.pin_levels ^ {rf_reg[R_INOPT1][3:2], rf_reg[R_INOPT0][3:2]};
    assign limit = {rf_reg[R_INOPT1][5:4], rf_reg[R_INOPT0][5:4]};
    assign int0  = |rf_reg[R_IMASK0][3:0];
    assign int1  = |rf_reg[R_IMASK1][3:0];

    always_comb
    begin
        rf_next     = rf_reg;
        pwm_on_next = pwm_on_reg;
        duty_next   = duty_reg;
        pullup_next = pullup_reg;
        drive_next  = drive_reg;
        rd          = 8'h00;
        save        = 1'b0;
        case (req.action)
            ACT_READ:
            begin
                if (in_file)
                begin
                    rd = rf_reg[idx];
                end
            end
            ACT_WRITE:
            begin
                if (in_file)
                begin
                    rf_next[idx] = req.write_data;
                    unique case (idx)
                        R_STATUS:
                        begin
                            if (!req.write_data[4])
                            begin
                                drive_next[0] = 1'b0;
                            end
                            if (!req.write_data[5])
                            begin
                                drive_next[1] = 1'b0;
                            end
                            // only the interrupt bits take the write, and only to clear
                            rf_next[idx] = (req.write_data | ~ST_INTS) & rf_reg[R_STATUS];
                        end
                        R_DIR:
                        begin
                            rf_next[idx] = {4'h0, req.write_data[3:0]};
                        end
                        R_SPEED1:
                        begin
                            if (req.write_data == 8'h00)
                            begin
                                pwm_on_next[0] = 1'b0;
                            end
                            else
                            begin
                                pwm_on_next[0] = 1'b1;
                                duty_next[0]   = req.write_data;
                            end
                        end
                        R_SPEED2:
                        begin
                            if (req.write_data == 8'h00)
                            begin
                                pwm_on_next[1] = 1'b0;
                            end
                            else
                            begin
                                pwm_on_next[1] = 1'b1;
                                duty_next[1]   = req.write_data;
                            end
                        end
                        R_INOPT0:
                        begin
                            pullup_next[1:0] = req.write_data[1:0];
                        end
                        R_INOPT1:
                        begin
                            pullup_next[3:2] = req.write_data[1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (req.reg_addr == SAVE_ADDR)
                begin
                    save = 1'b1;
                end
            end
            ACT_PIN:
            begin
                rf_next[R_STATUS] = {rf_reg[R_STATUS][7:6],
                                     rf_reg[R_STATUS][5] | int1,
                                     rf_reg[R_STATUS][4] | int0,
                                     val};
                rf_next[R_DIR]    = rf_reg[R_DIR] & ~{4'h0, val & limit};
                drive_next        = drive_reg | {int1, int0};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.read_data      = rd;
        result.direction_pins = rf_next[R_DIR][3:0];
        result.pwm_enable     = pwm_on_next;
        result.duty_m1        = duty_next[0];
        result.duty_m2        = duty_next[1];
        result.pullups        = pullup_next;
        result.int_drive      = drive_next;
        result.save_request   = save;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                rf_reg[i] <= 8'h00;
            end
            rf_reg[R_ADDR] <= ADDR_DEFAULT;
            pwm_on_reg     <= 2'b00;
            duty_reg[0]    <= 8'h00;
            duty_reg[1]    <= 8'h00;
            pullup_reg     <= 4'h0;
            drive_reg      <= 2'b00;
        end
        else if (step)
        begin
            rf_reg     <= rf_next;
            pwm_on_reg <= pwm_on_next;
            duty_reg   <= duty_next;
            pullup_reg <= pullup_next;
            drive_reg  <= drive_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/mdrd_out_stage.sv @@
`default_nettype none
module mdrd_out_stage (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  mdrd_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  wire               out_ready,
    output mdrd_pkg::result_t out_result
);
    import mdrd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

@@ rtl/motor_driver_register_device_core.sv @@
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: reg_addr, write_data, pin_levels
// m_*       out  m_tvalid/m_tready  tdata: read_data .. save_request (see port comment)
//
// Each request gives exactly one result. When the output is free, the result
// is computed from the input register and loaded into the result register.
// One request per cycle is sustained while the output does not stall.
// The register-file update is a single pass between the input register and
// the result register.
// Reset (rst_n low, async) clears the handshake state and the register set
// (slave address 0x26, all else zero).
// A stalled result holds in the output register; the input register still
// takes a request while the output is full, then s_tready drops.
`default_nettype none
module motor_driver_register_device_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,  // [7:0] reg_addr, [15:8] write_data, [19:16] pin_levels
    input  wire  [1:0]  s_tuser,  // [1:0] action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata   // [7:0] read_data, [11:8] direction_pins,
                                  // [13:12] pwm_enable, [21:14] duty_m1,
                                  // [29:22] duty_m2, [33:30] pullups,
                                  // [35:34] int_drive, [36] save_request
);
    import mdrd_pkg::*;

    req_t    in_req;
    req_t    req;
    logic    req_valid;
    logic    out_free;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_req.action     = action_t'(s_tuser);
    assign in_req.reg_addr   = s_tdata[7:0];
    assign in_req.write_data = s_tdata[15:8];
    assign in_req.pin_levels = s_tdata[19:16];

    // one request moves from the input register through the update when
    // the result register can take its result
    assign advance = req_valid && out_free;

    mdrd_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    mdrd_regfile u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .req    (req),
        .result (result)
    );

    mdrd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {3'b000,
                      out_result.save_request,
                      out_result.int_drive,
                      out_result.pullups,
                      out_result.duty_m2,
                      out_result.duty_m1,
                      out_result.pwm_enable,
                      out_result.direction_pins,
                      out_result.read_data};

endmodule
`default_nettype wire

@@ rtl/mdrd_checker.sv @@
`default_nettype none
module mdrd_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a result only leaves through a handshake
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without handshake");

    // input side only blocks when both stages are full and the output stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked with free output");

    // a save request comes from a write, which never returns read data
    a_save_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[36] |-> m_tdata[7:0] == 8'h00)
        else $error("read data on save request");

endmodule

bind motor_driver_register_device_core mdrd_checker u_mdrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ bench/motor_driver_register_device_core_tb.sv @@
`timescale 1ns / 1ps
module motor_driver_register_device_core_tb;
    import mdrd_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int RAND_ITEMS  = 1600;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] reg_addr, [15:8] write_data, [19:16] pin_levels
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [7:0] read_data, [11:8] direction_pins, [13:12] pwm_enable,
                            // [21:14] duty_m1, [29:22] duty_m2, [33:30] pullups,
                            // [35:34] int_drive, [36] save_request

    motor_driver_register_device_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted device state
    logic [7:0] regs [NREGS];
    logic [1:0] pwm_q;
    logic [7:0] duty_q [2];
    logic [3:0] pullup_q;
    logic [1:0] irq_q;

    result_t pending_results [$];
    int      mismatches;
    int      idle_cycles;
    int      burst_left;
    bit      pace_on;
    int      ready_mode;
    int      ready_cyc;
    result_t got_res;
    result_t want_res;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // one request through the device model, returns the result it causes
    function automatic result_t device_step(action_t act, logic [7:0] addr,
                                            logic [7:0] wdata, logic [3:0] lv);
        result_t    r;
        logic [3:0] idx;
        logic [7:0] v;
        logic [7:0] opts;
        logic       val;
        int         m;
        int         sub;
        r   = '0;
        idx = addr[3:0];
        v   = wdata;
        case (act)
            ACT_READ:
                if (addr < NREGS_ADDR)
                    r.read_data = regs[idx];
            ACT_WRITE:
                if (addr < NREGS_ADDR)
                begin
                    case (idx)
                        R_STATUS:
                        begin
                            // a zero in an interrupt bit drops its line, set only clears
                            if (!v[4]) irq_q[0] = 1'b0;
                            if (!v[5]) irq_q[1] = 1'b0;
                            v = (v | ~ST_INTS) & regs[R_STATUS];
                        end
                        R_DIR:
                            v = v & 8'h0F;
                        R_SPEED1, R_SPEED2:
                        begin
                            m = (idx == R_SPEED2) ? 1 : 0;
                            if (v == 8'h00)
                                pwm_q[m] = 1'b0;
                            else
                            begin
                                pwm_q[m]  = 1'b1;
                                duty_q[m] = v;
                            end
                        end
                        R_INOPT0:
                            pullup_q[1:0] = v[1:0];
                        R_INOPT1:
                            pullup_q[3:2] = v[1:0];
                        default: ;
                    endcase
                    regs[idx] = v;
                end
                else if (addr == SAVE_ADDR)
                    r.save_request = 1'b1;
            ACT_PIN:
                for (int i = 0; i < 4; i++)
                begin
                    opts = (i < 2) ? regs[R_INOPT0] : regs[R_INOPT1];
                    sub  = i & 1;
                    val  = lv[i];
                    if (opts[2 + sub]) val = ~val;
                    regs[R_STATUS][i] = val;
                    // limit input stops the matching direction
                    if (val && opts[4 + sub] && regs[R_DIR][i])
                        regs[R_DIR][i] = 1'b0;
                    if (regs[R_IMASK0][i])
                    begin
                        regs[R_STATUS][4] = 1'b1;
                        irq_q[0] = 1'b1;
                    end
                    if (regs[R_IMASK1][i])
                    begin
                        regs[R_STATUS][5] = 1'b1;
                        irq_q[1] = 1'b1;
                    end
                end
            default: ;
        endcase
        r.direction_pins = regs[R_DIR][3:0];
        r.pwm_enable     = pwm_q;
        r.duty_m1        = duty_q[0];
        r.duty_m2        = duty_q[1];
        r.pullups        = pullup_q;
        r.int_drive      = irq_q;
        return r;
    endfunction

    function automatic result_t unpack_result(logic [39:0] d);
        result_t r;
        r.read_data      = d[7:0];
        r.direction_pins = d[11:8];
        r.pwm_enable     = d[13:12];
        r.duty_m1        = d[21:14];
        r.duty_m2        = d[29:22];
        r.pullups        = d[33:30];
        r.int_drive      = d[35:34];
        r.save_request   = d[36];
        return r;
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic send_req(input action_t act, input logic [7:0] addr,
                            input logic [7:0] wdata, input logic [3:0] lv);
        int gap;
        if (pace_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'h0, lv, wdata, addr};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(device_step(act, addr, wdata, lv));
    endtask

    // hold off the sender until every pending result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_req(ACT_READ, 8'd0, 8'h00, 4'h0);
        send_req(ACT_READ, 8'd1, 8'hFF, 4'hF);
        send_req(ACT_READ, 8'd2, 8'h00, 4'h0);
        send_req(ACT_READ, 8'd9, 8'h00, 4'h0);
        send_req(ACT_READ, 8'd10, 8'h00, 4'h0);   // just past the file
        send_req(ACT_READ, 8'd255, 8'h00, 4'h0);
    endtask

    task automatic test_side_effects();
        send_req(ACT_WRITE, 8'd6, 8'h3F, 4'h0);   // pullups, invert, limit on inputs 0/1
        send_req(ACT_WRITE, 8'd7, 8'h00, 4'h0);
        send_req(ACT_WRITE, 8'd2, 8'hFF, 4'h0);   // direction masked to low nibble
        send_req(ACT_WRITE, 8'd4, 8'hFF, 4'h0);
        send_req(ACT_WRITE, 8'd5, 8'h01, 4'h0);
        send_req(ACT_WRITE, 8'd8, 8'h01, 4'h0);
        send_req(ACT_WRITE, 8'd9, 8'h0C, 4'h0);
        send_req(ACT_PIN, 8'h00, 8'h00, 4'h0);    // inverted low inputs hit the limits
        send_req(ACT_PIN, 8'hFF, 8'hFF, 4'hF);    // masked inputs interrupt at any level
        send_req(ACT_READ, 8'd1, 8'h00, 4'h0);
        send_req(ACT_WRITE, 8'd1, 8'h30, 4'h0);   // keep both interrupts
        send_req(ACT_WRITE, 8'd1, 8'h00, 4'h0);   // release both lines
        send_req(ACT_WRITE, 8'd1, 8'h20, 4'h0);   // release on an already clear bit
        send_req(ACT_WRITE, 8'd4, 8'h00, 4'h0);   // zero speed keeps the old duty
        send_req(ACT_READ, 8'd4, 8'h00, 4'h0);
        send_req(ACT_WRITE, 8'd127, 8'h55, 4'h0); // save request
        send_req(ACT_WRITE, 8'd200, 8'hAA, 4'h0); // outside the file, ignored
        send_req(ACT_NONE, 8'd2, 8'hFF, 4'hF);
        send_req(ACT_WRITE, 8'd3, 8'hAA, 4'h0);
        send_req(ACT_READ, 8'd3, 8'h00, 4'h0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int      pick;
        action_t act;
        logic [7:0] addr;
        logic [7:0] wdata;
        for (int ph = 0; ph < 4; ph++)
        begin
            ready_mode = ph;
            pace_on    = (ph != 1);
            burst_left = 0;
            for (int k = 0; k < n_items / 4; k++)
            begin
                pick  = $urandom_range(0, 99);
                addr  = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
                wdata = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
                if (pick < 30)
                    act = ACT_READ;
                else if (pick < 68)
                    act = ACT_WRITE;
                else if (pick < 94)
                    act = ACT_PIN;
                else if (pick < 97)
                begin
                    act  = ACT_WRITE;
                    addr = SAVE_ADDR;
                end
                else
                    act = ACT_NONE;
                send_req(act, addr, wdata, 4'($urandom));
            end
            drain_results();
        end
    endtask

    // receiver stall pattern, changes with the phase
    always @(negedge clk)
    begin
        ready_cyc <= ready_cyc + 1;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_cyc[3:0] < 4'd3);
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = unpack_result(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h at %0t", m_tdata, $time);
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res !== want_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $time);
                        $display("  exp rd=%h dir=%h pwm=%h d1=%h d2=%h pu=%h int=%h save=%b",
                                 want_res.read_data, want_res.direction_pins,
                                 want_res.pwm_enable, want_res.duty_m1, want_res.duty_m2,
                                 want_res.pullups, want_res.int_drive, want_res.save_request);
                        $display("  got rd=%h dir=%h pwm=%h d1=%h d2=%h pu=%h int=%h save=%b",
                                 got_res.read_data, got_res.direction_pins,
                                 got_res.pwm_enable, got_res.duty_m1, got_res.duty_m2,
                                 got_res.pullups, got_res.int_drive, got_res.save_request);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no request or result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_READ;
        m_tready   = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        pace_on    = 1'b1;
        ready_mode = 1;
        ready_cyc  = 0;
        for (int i = 0; i < NREGS; i++) regs[i] = 8'h00;
        regs[R_ADDR] = ADDR_DEFAULT;
        pwm_q     = '0;
        duty_q[0] = '0;
        duty_q[1] = '0;
        pullup_q  = '0;
        irq_q     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_side_effects();
        drain_results();
        test_random_traffic(RAND_ITEMS);
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
